// ===== rtl/core/stereo_match_scene_flow_top_assert.svh =====
// Assertion macros for the scene flow RTL, used by the queue
`ifndef STEREO_MATCH_SCENE_FLOW_TOP_ASSERT_SVH
`define STEREO_MATCH_SCENE_FLOW_TOP_ASSERT_SVH

// check a property once reset is released
`define SMSF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("scene flow assertion failed");

// check a property on every edge, reset included
`define SMSF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("scene flow assertion failed");

`endif

// ===== rtl/core/smsf_pkg.sv =====
// Types, constants and helpers for the stereo scene flow block
`timescale 1ns / 1ps
`default_nettype none
package smsf_pkg;
    localparam int COORD_FRAC_BITS = 4;
    localparam int OUT_FRAC_BITS   = 16;
    localparam int BASE_FRAC_BITS  = 14;
    localparam int NUM_SHIFT = (OUT_FRAC_BITS > BASE_FRAC_BITS) ?
                               OUT_FRAC_BITS - BASE_FRAC_BITS : 0;
    localparam int DEN_SHIFT = (BASE_FRAC_BITS > OUT_FRAC_BITS) ?
                               BASE_FRAC_BITS - OUT_FRAC_BITS : 0;
    localparam int NUM_W = 32 + NUM_SHIFT;
    localparam int DEN_W = 16 + DEN_SHIFT;
    localparam int SV_W  = NUM_W + 2;
    localparam int LANES = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [SV_W-1:0] S32_MAX = SV_W'(64'sd2147483647);
    localparam logic signed [SV_W-1:0] S32_MIN = SV_W'(-64'sd2147483648);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL  = 2'd0,
        CFG_CU     = 2'd1,
        CFG_CV     = 2'd2,
        CFG_BASE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] cur_left_u;
        logic [15:0] cur_right_u;
        logic [15:0] cur_left_v;
        logic [15:0] prev_left_u;
        logic [15:0] prev_right_u;
        logic [15:0] prev_left_v;
    } t_in;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic [30:0]        cur_z;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic [30:0]        prev_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [11:0]        pixel_u;
        logic [11:0]        pixel_v;
    } t_out;

    typedef struct packed {
        logic [15:0] focal;
        logic [15:0] cu;
        logic [15:0] cv;
        logic [15:0] base;
    } t_cfg;

    // lanes: cur x, cur y, cur z, prev x, prev y, prev z
    typedef struct packed {
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][31:0]  prod;
        logic [15:0]             dc;
        logic [15:0]             dp;
        logic [11:0]             pix_u;
        logic [11:0]             pix_v;
    } t_job;

    typedef struct packed {
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][DEN_W-1:0]  rem;
        logic [LANES-1:0][NUM_W-1:0]  nq;
        logic [DEN_W-1:0]             dc;
        logic [DEN_W-1:0]             dp;
        logic [11:0]                  pix_u;
        logic [11:0]                  pix_v;
    } t_stage;

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [SV_W-1:0] v);
        logic signed [SV_W-1:0] t;
        t = v;
        if (t > S32_MAX) t = S32_MAX;
        if (t < S32_MIN) t = S32_MIN;
        return t[31:0];
    endfunction

    function automatic logic [30:0] sat_u31(input logic signed [SV_W-1:0] v);
        logic signed [SV_W-1:0] t;
        t = v;
        if (t < 0) t = '0;
        if (t > S32_MAX) t = S32_MAX;
        return t[30:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/smsf_front.sv =====
// Front end: disparity check, sign split and baseline products
`timescale 1ns / 1ps
`default_nettype none
module smsf_front import smsf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_job      o_job
);
    logic        r_valid;
    t_job        r_job;
    t_job        n_job;
    logic        n_keep;
    logic [15:0] dc, dp;
    logic [LANES-1:0][15:0] mag;
    logic [LANES-1:0]       neg;
    logic signed [16:0]     diff [4];

    always_comb begin
        dc = abs_diff(i_in.cur_left_u, i_in.cur_right_u);
        dp = abs_diff(i_in.prev_left_u, i_in.prev_right_u);
        diff[0] = $signed({1'b0, i_in.cur_left_u})  - $signed({1'b0, i_cfg.cu});
        diff[1] = $signed({1'b0, i_in.cur_left_v})  - $signed({1'b0, i_cfg.cv});
        diff[2] = $signed({1'b0, i_in.prev_left_u}) - $signed({1'b0, i_cfg.cu});
        diff[3] = $signed({1'b0, i_in.prev_left_v}) - $signed({1'b0, i_cfg.cv});
        for (int k = 0; k < 4; k++) begin
            neg[(k / 2) * 3 + (k % 2)] = diff[k][16];
            mag[(k / 2) * 3 + (k % 2)] = diff[k][16] ? 16'(-diff[k]) : diff[k][15:0];
        end
        neg[2] = 1'b0;
        neg[5] = 1'b0;
        mag[2] = i_cfg.focal;
        mag[5] = i_cfg.focal;
        n_job.neg = neg;
        for (int k = 0; k < LANES; k++) begin
            n_job.prod[k] = {16'd0, mag[k]} * {16'd0, i_cfg.base};
        end
        n_job.dc    = dc;
        n_job.dp    = dp;
        n_job.pix_u = 12'(i_in.cur_left_u >> COORD_FRAC_BITS);
        n_job.pix_v = 12'(i_in.cur_left_v >> COORD_FRAC_BITS);
        // drop matches with zero disparity in either frame
        n_keep = (dc != 16'd0) && (dp != 16'd0);
    end

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid && n_keep;
        end
        if (!o_stall) begin
            r_job <= n_job;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/smsf_fifo.sv =====
// Short queue between front end and divider back end
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_match_scene_flow_top_assert.svh"
module smsf_fifo import smsf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_full,
    output logic      o_empty
);
    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_job;
    end

    `SMSF_ASSERT(a_no_overflow, i_push |-> !o_full)
    `SMSF_ASSERT(a_no_underflow, i_pop |-> !o_empty)
    `SMSF_ASSERT(a_cnt_bound, r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
    `SMSF_ASSERT(a_ptr_track, (r_wr - r_rd) == r_cnt[FIFO_AW-1:0])
    `SMSF_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> o_empty)
endmodule
`default_nettype wire

// ===== rtl/core/smsf_back.sv =====
// Back end: six-lane pipelined restoring divider and saturation
`timescale 1ns / 1ps
`default_nettype none
module smsf_back import smsf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_out
);
    t_stage r_stg [NUM_W+1];
    logic   r_v   [NUM_W+1];
    logic   r_ovalid;
    t_out   r_out;
    t_out   n_out;
    t_stage n_first;
    logic   en;

    // one quotient bit per lane per stage
    function automatic t_stage div_step(input t_stage s);
        t_stage           r;
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] d;
        r = s;
        for (int k = 0; k < LANES; k++) begin
            d = (k < 3) ? s.dc : s.dp;
            t = {s.rem[k], s.nq[k][NUM_W-1]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                r.nq[k] = {s.nq[k][NUM_W-2:0], 1'b1};
            end else begin
                r.nq[k] = {s.nq[k][NUM_W-2:0], 1'b0};
            end
            r.rem[k] = t[DEN_W-1:0];
        end
        return r;
    endfunction

    assign en    = !r_ovalid || !i_stall;
    assign o_pop = en && !i_empty;

    always_comb begin
        n_first.neg = i_job.neg;
        for (int k = 0; k < LANES; k++) begin
            n_first.rem[k] = '0;
            n_first.nq[k]  = NUM_W'(i_job.prod[k]) << NUM_SHIFT;
        end
        n_first.dc    = DEN_W'(i_job.dc) << DEN_SHIFT;
        n_first.dp    = DEN_W'(i_job.dp) << DEN_SHIFT;
        n_first.pix_u = i_job.pix_u;
        n_first.pix_v = i_job.pix_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
        end
        if (en) r_stg[0] <= n_first;
    end

    for (genvar g = 1; g <= NUM_W; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (en) begin
                r_v[g] <= r_v[g-1];
            end
            if (en) r_stg[g] <= div_step(r_stg[g-1]);
        end
    end

    always_comb begin
        logic signed [SV_W-1:0] val [LANES];
        for (int k = 0; k < LANES; k++) begin
            val[k] = r_stg[NUM_W].neg[k] ? -$signed(SV_W'(r_stg[NUM_W].nq[k]))
                                         :  $signed(SV_W'(r_stg[NUM_W].nq[k]));
        end
        n_out.cur_x   = sat_s32(val[0]);
        n_out.cur_y   = sat_s32(val[1]);
        n_out.cur_z   = sat_u31(val[2]);
        n_out.prev_x  = sat_s32(val[3]);
        n_out.prev_y  = sat_s32(val[4]);
        n_out.prev_z  = sat_u31(val[5]);
        n_out.vel_x   = sat_s32(val[0] - val[3]);
        n_out.vel_y   = sat_s32(val[1] - val[4]);
        n_out.vel_z   = sat_s32(val[2] - val[5]);
        n_out.pixel_u = r_stg[NUM_W].pix_u;
        n_out.pixel_v = r_stg[NUM_W].pix_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_v[NUM_W];
        end
        if (en) r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;
endmodule
`default_nettype wire

// ===== rtl/core/stereo_match_scene_flow_top.sv =====
// Top level of the stereo triangulation scene flow block
//
//  channel  | direction | handshake                   | word
//  ---------+-----------+-----------------------------+--------------
//  input    | in        | i_in_valid / o_in_stall     | i_in  (t_in)
//  result   | out       | o_out_valid / i_out_stall   | o_out (t_out)
//  config   | in        | i_cfg_we (no handshake)     | i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while no stall is asserted; a result passes
// through the front register, queue, NUM_W+1 divider stages (35) and output.
// The divider pipeline retires one quotient bit per stage for all six lanes.
// Matches with zero disparity are accepted and dropped, giving no result.
// Synchronous active-low reset clears all valids and loads register defaults.
// A stalled result freezes the divider; the queue absorbs the front end.
`timescale 1ns / 1ps
`default_nettype none
module stereo_match_scene_flow_top import smsf_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data
);
    t_cfg r_cfg;
    t_job f_job, q_job;
    logic push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal <= 16'd11536;
            r_cfg.cu    <= 16'd9840;
            r_cfg.cv    <= 16'd2880;
            r_cfg.base  <= 16'd8847;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL: r_cfg.focal <= i_cfg_data;
                CFG_CU:    r_cfg.cu    <= i_cfg_data;
                CFG_CV:    r_cfg.cv    <= i_cfg_data;
                CFG_BASE:  r_cfg.base  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    smsf_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(i_in_valid), .o_stall(o_in_stall), .i_in,
        .i_full(full), .o_push(push), .o_job(f_job)
    );

    smsf_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_job(f_job),
        .i_pop(pop), .o_job(q_job), .o_full(full), .o_empty(empty)
    );

    smsf_back u_back (
        .i_clk, .i_rst_n, .i_job(q_job), .i_empty(empty), .o_pop(pop),
        .o_valid(o_out_valid), .i_stall(i_out_stall), .o_out
    );
endmodule
`default_nettype wire
